[sv/lcrm_pkg.sv]
package lcrm_pkg;

  // Widths fixed by the item fields.
  localparam int VALUE_W = 10;
  localparam int LEN_W   = 11;

  // Set tags kept in the presence memory. Tag zero means "never seen".
  localparam int                 EPOCH_W   = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  // Presence of the item's own value and of its two neighbors in the current set.
  typedef struct packed {
    logic dup_hit;
    logic up_hit;
    logic dn_hit;
  } pres_hits_t;

  // Interval written back to the endpoint tables.
  typedef struct packed {
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
  } span_t;

endpackage

[sv/longest_consecutive_run_merge.sv]
// Channel   Handshake                  Payload            Beat
// input     in_valid_i / in_ready_o    value_i, last_i    one set element
// output    out_valid_o / out_ready_i  longest_length_o   one run length per set
//
// A beat is accepted every cycle in steady state: its memory reads issue on the accepting
// edge and its merge and write-back complete as it leaves the merge stage, so one beat is
// in the merge stage while the next one is read. The result of a set is registered as the
// beat marked last leaves the merge stage and waits in an output register. After reset,
// and after every 255th set, the presence memory is swept over all (VALUE_COUNT + 1) / 2
// words, during which no beat is accepted. A stalled output holds back input only when
// the beat in the merge stage is itself marked last.
module longest_consecutive_run_merge #(
  parameter int VALUE_COUNT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lcrm_pkg::VALUE_W-1:0]  value_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lcrm_pkg::LEN_W-1:0]    longest_length_o
);

  localparam int VW = lcrm_pkg::VALUE_W;
  localparam int LW = lcrm_pkg::LEN_W;

  // Merge stage: the beat whose memory reads were issued on the last accepting edge.
  logic                         x_valid_q;
  logic [VW-1:0]                x_value_q;
  logic                         x_last_q;

  // Presence is tagged with a set number, so closing a set clears the whole bitmap at once.
  logic [lcrm_pkg::EPOCH_W-1:0] epoch_q;
  logic [LW-1:0]                best_q;
  logic                         out_valid_q;
  logic [LW-1:0]                out_len_q;

  logic                         in_accept;
  logic                         x_adv;
  logic                         x_wrap;
  logic                         pres_busy;
  lcrm_pkg::pres_hits_t         hits;
  logic [VW-1:0]                end_up;
  logic [VW-1:0]                start_dn;
  logic                         v_ok;
  logic                         up_ok;
  logic                         dn_ok;
  logic                         commit;
  lcrm_pkg::span_t              span;
  logic [LW-1:0]                span_len;
  logic [LW-1:0]                best_new;

  // The beat in the merge stage leaves unless it closes a set and the output slot is taken.
  assign x_adv      = x_valid_q && !(x_last_q && out_valid_q && !out_ready_i);
  // Closing the set with the highest tag starts the sweep, so no beat may follow it at once.
  assign x_wrap     = x_valid_q && x_last_q && (epoch_q == lcrm_pkg::EPOCH_MAX);
  assign in_ready_o = !pres_busy && (!x_valid_q || x_adv) && !x_wrap;
  assign in_accept  = in_valid_i && in_ready_o;

  // Values beyond the table are dropped; so are the neighbor checks that leave it.
  always_comb begin
    v_ok  = 32'(x_value_q) < 32'(VALUE_COUNT);
    up_ok = (32'(x_value_q) + 32'd1) < 32'(VALUE_COUNT);
    dn_ok = (x_value_q != '0);
  end

  // The new value joins the interval ending just below it and the one starting just above.
  always_comb begin
    commit  = x_valid_q && v_ok && !hits.dup_hit;
    span.hi = (up_ok && hits.up_hit) ? end_up : x_value_q;
    span.lo = (dn_ok && hits.dn_hit) ? start_dn : x_value_q;
    if (span.hi >= span.lo) begin
      span_len = LW'(span.hi) - LW'(span.lo) + LW'(1);
    end else begin
      span_len = LW'(1);
    end
    best_new = (commit && (span_len > best_q)) ? span_len : best_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q <= 1'b0;
      x_value_q <= '0;
      x_last_q  <= 1'b0;
    end else if (in_accept) begin
      x_valid_q <= 1'b1;
      x_value_q <= value_i;
      x_last_q  <= last_i;
    end else if (x_adv) begin
      x_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= lcrm_pkg::EPOCH_FIRST;
      best_q  <= '0;
    end else if (x_adv) begin
      if (x_last_q) begin
        best_q  <= '0;
        epoch_q <= x_wrap ? lcrm_pkg::EPOCH_FIRST : (epoch_q + lcrm_pkg::EPOCH_W'(1));
      end else begin
        best_q <= best_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (x_adv && x_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (x_adv && x_last_q) begin
      out_len_q <= best_new;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign longest_length_o = out_len_q;

  lcrm_presence #(
    .VALUE_COUNT (VALUE_COUNT)
  ) u_presence (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_accept),
    .rd_value_i (value_i),
    .wr_en_i    (x_adv && commit),
    .epoch_i    (epoch_q),
    .clear_i    (x_adv && x_wrap),
    .hits_o     (hits),
    .busy_o     (pres_busy)
  );

  lcrm_endpoints #(
    .VALUE_COUNT (VALUE_COUNT)
  ) u_endpoints (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_accept),
    .rd_value_i (value_i),
    .wr_en_i    (x_adv && commit),
    .span_i     (span),
    .end_up_o   (end_up),
    .start_dn_o (start_dn)
  );

endmodule

[sv/lcrm_ram.sv]
module lcrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Read-first: a read and a write to the same entry in one cycle return the old data.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[sv/lcrm_presence.sv]
module lcrm_presence #(
  parameter int VALUE_COUNT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [lcrm_pkg::VALUE_W-1:0]  rd_value_i,
  input  logic                          wr_en_i,
  input  logic [lcrm_pkg::EPOCH_W-1:0]  epoch_i,
  input  logic                          clear_i,
  output lcrm_pkg::pres_hits_t          hits_o,
  output logic                          busy_o
);

  // Two tags per word, so a value and both its neighbors span at most two words.
  localparam int WORDS = (VALUE_COUNT + 1) / 2;
  localparam int WAW   = $clog2(WORDS);
  localparam int EXT_W = lcrm_pkg::VALUE_W + WAW;
  localparam int TW    = lcrm_pkg::EPOCH_W;

  logic [EXT_W-1:0]  v_ext;
  logic [EXT_W-1:0]  wa_ext;
  logic [EXT_W-1:0]  wb_ext;
  logic [WAW-1:0]    rd_addr_a;
  logic [WAW-1:0]    rd_addr_b;
  logic [WAW-1:0]    addr_a_q;
  logic [WAW-1:0]    addr_b_q;
  logic              par_q;

  logic [2*TW-1:0]   ram_a_data;
  logic [2*TW-1:0]   ram_b_data;
  logic [2*TW-1:0]   word_a;
  logic [2*TW-1:0]   word_b;
  logic [2*TW-1:0]   new_word;

  logic              fwd_valid_q;
  logic [WAW-1:0]    fwd_addr_q;
  logic [2*TW-1:0]   fwd_data_q;

  logic              clr_active_q;
  logic [WAW-1:0]    clr_addr_q;

  logic              ram_wr_en;
  logic [WAW-1:0]    ram_wr_addr;
  logic [2*TW-1:0]   ram_wr_data;

  // Port A reads the word holding the value, port B the word holding the other neighbor.
  always_comb begin
    v_ext  = EXT_W'(rd_value_i);
    wa_ext = v_ext >> 1;
    wb_ext = rd_value_i[0] ? (wa_ext + EXT_W'(1)) : (wa_ext - EXT_W'(1));
    if ((rd_value_i == '0) || (wb_ext >= EXT_W'(WORDS))) begin
      wb_ext = wa_ext;
    end
    rd_addr_a = wa_ext[WAW-1:0];
    rd_addr_b = wb_ext[WAW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_q    <= 1'b0;
      addr_a_q <= '0;
      addr_b_q <= '0;
    end else if (rd_en_i) begin
      par_q    <= rd_value_i[0];
      addr_a_q <= rd_addr_a;
      addr_b_q <= rd_addr_b;
    end
  end

  assign word_a = (fwd_valid_q && (fwd_addr_q == addr_a_q)) ? fwd_data_q : ram_a_data;
  assign word_b = (fwd_valid_q && (fwd_addr_q == addr_b_q)) ? fwd_data_q : ram_b_data;

  always_comb begin
    if (par_q) begin
      hits_o.dup_hit = (word_a[2*TW-1:TW] == epoch_i);
      hits_o.dn_hit  = (word_a[TW-1:0]    == epoch_i);
      hits_o.up_hit  = (word_b[TW-1:0]    == epoch_i);
      new_word       = {epoch_i, word_a[TW-1:0]};
    end else begin
      hits_o.dup_hit = (word_a[TW-1:0]    == epoch_i);
      hits_o.up_hit  = (word_a[2*TW-1:TW] == epoch_i);
      hits_o.dn_hit  = (word_b[2*TW-1:TW] == epoch_i);
      new_word       = {word_a[2*TW-1:TW], epoch_i};
    end
  end

  always_comb begin
    ram_wr_en   = clr_active_q || wr_en_i;
    ram_wr_addr = clr_active_q ? clr_addr_q : addr_a_q;
    ram_wr_data = clr_active_q ? '0 : new_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      if (clr_addr_q == WAW'(WORDS - 1)) begin
        clr_active_q <= 1'b0;
        clr_addr_q   <= '0;
      end else begin
        clr_addr_q <= clr_addr_q + WAW'(1);
      end
    end else if (clear_i) begin
      clr_active_q <= 1'b1;
    end
  end

  // The last word written, for a read issued in the same cycle as that write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
      fwd_addr_q  <= '0;
      fwd_data_q  <= '0;
    end else if (clear_i || clr_active_q) begin
      fwd_valid_q <= 1'b0;
    end else if (wr_en_i) begin
      fwd_valid_q <= 1'b1;
      fwd_addr_q  <= addr_a_q;
      fwd_data_q  <= new_word;
    end
  end

  lcrm_ram #(
    .WIDTH (2 * TW),
    .DEPTH (WORDS)
  ) u_tag_ram_a (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (rd_en_i),
    .rd_addr_i (rd_addr_a),
    .rd_data_o (ram_a_data)
  );

  lcrm_ram #(
    .WIDTH (2 * TW),
    .DEPTH (WORDS)
  ) u_tag_ram_b (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (rd_en_i),
    .rd_addr_i (rd_addr_b),
    .rd_data_o (ram_b_data)
  );

  assign busy_o = clr_active_q;

endmodule

[sv/lcrm_endpoints.sv]
module lcrm_endpoints #(
  parameter int VALUE_COUNT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [lcrm_pkg::VALUE_W-1:0]  rd_value_i,
  input  logic                          wr_en_i,
  input  lcrm_pkg::span_t               span_i,
  output logic [lcrm_pkg::VALUE_W-1:0]  end_up_o,
  output logic [lcrm_pkg::VALUE_W-1:0]  start_dn_o
);

  localparam int AW    = $clog2(VALUE_COUNT);
  localparam int VW    = lcrm_pkg::VALUE_W;
  localparam int EXT_W = VW + 1 + AW;

  logic [EXT_W-1:0] up_ext;
  logic [EXT_W-1:0] dn_ext;
  logic [EXT_W-1:0] lo_ext;
  logic [EXT_W-1:0] hi_ext;
  logic [AW-1:0]    e_rd_addr;
  logic [AW-1:0]    s_rd_addr;
  logic [AW-1:0]    e_addr_q;
  logic [AW-1:0]    s_addr_q;
  logic [AW-1:0]    lo_addr;
  logic [AW-1:0]    hi_addr;
  logic [VW-1:0]    e_ram_data;
  logic [VW-1:0]    s_ram_data;

  logic             fwd_valid_q;
  logic [AW-1:0]    fwd_e_addr_q;
  logic [VW-1:0]    fwd_e_data_q;
  logic [AW-1:0]    fwd_s_addr_q;
  logic [VW-1:0]    fwd_s_data_q;

  always_comb begin
    up_ext    = EXT_W'(rd_value_i) + EXT_W'(1);
    dn_ext    = EXT_W'(rd_value_i) - EXT_W'(1);
    lo_ext    = EXT_W'(span_i.lo);
    hi_ext    = EXT_W'(span_i.hi);
    e_rd_addr = up_ext[AW-1:0];
    s_rd_addr = dn_ext[AW-1:0];
    lo_addr   = lo_ext[AW-1:0];
    hi_addr   = hi_ext[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_addr_q <= '0;
      s_addr_q <= '0;
    end else if (rd_en_i) begin
      e_addr_q <= e_rd_addr;
      s_addr_q <= s_rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q  <= 1'b0;
      fwd_e_addr_q <= '0;
      fwd_e_data_q <= '0;
      fwd_s_addr_q <= '0;
      fwd_s_data_q <= '0;
    end else if (wr_en_i) begin
      fwd_valid_q  <= 1'b1;
      fwd_e_addr_q <= lo_addr;
      fwd_e_data_q <= span_i.hi;
      fwd_s_addr_q <= hi_addr;
      fwd_s_data_q <= span_i.lo;
    end
  end

  assign end_up_o   = (fwd_valid_q && (fwd_e_addr_q == e_addr_q)) ? fwd_e_data_q : e_ram_data;
  assign start_dn_o = (fwd_valid_q && (fwd_s_addr_q == s_addr_q)) ? fwd_s_data_q : s_ram_data;

  // Maps an interval's first value to its last.
  lcrm_ram #(
    .WIDTH (VW),
    .DEPTH (VALUE_COUNT)
  ) u_end_of_start (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en_i),
    .wr_addr_i (lo_addr),
    .wr_data_i (span_i.hi),
    .rd_en_i   (rd_en_i),
    .rd_addr_i (e_rd_addr),
    .rd_data_o (e_ram_data)
  );

  // Maps an interval's last value to its first.
  lcrm_ram #(
    .WIDTH (VW),
    .DEPTH (VALUE_COUNT)
  ) u_start_of_end (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en_i),
    .wr_addr_i (hi_addr),
    .wr_data_i (span_i.lo),
    .rd_en_i   (rd_en_i),
    .rd_addr_i (s_rd_addr),
    .rd_data_o (s_ram_data)
  );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

// Stimulus for the longest consecutive run block. A short table of directed sets
// comes first. Random sets follow: short clustered sets that merge neighbors, some
// sets of scattered values, and one set that holds the whole value domain. A local
// model of the interval tables predicts each run length the table does not give, and a
// monitor on the output channel checks each result beat against the oldest prediction.
module tb;

  localparam int VALUE_W     = lcrm_pkg::VALUE_W;
  localparam int LEN_W       = lcrm_pkg::LEN_W;
  localparam int DOMAIN      = 1024;
  localparam int CLK_HALF    = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_LIMIT = 20000;
  localparam int PRINT_LIMIT = 30;
  // Marks a directed row whose run length comes from the local model.
  localparam int PREDICTED   = -1;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [VALUE_W-1:0] value_i = '0;
  logic               last_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [LEN_W-1:0]   longest_length_o;

  longest_consecutive_run_merge #(
    .VALUE_COUNT(DOMAIN)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .value_i          (value_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .longest_length_o (longest_length_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Local copy of the merge state: which values the current set holds, the far
  // end of each interval keyed by either endpoint, and the longest run so far.
  logic               seen_in_set [DOMAIN];
  logic [VALUE_W-1:0] run_end_at  [DOMAIN];
  logic [VALUE_W-1:0] run_start_at[DOMAIN];
  logic [LEN_W-1:0]   best_run;

  logic [LEN_W-1:0]   pending_lengths[$];

  int cycle_count   = 0;
  int error_count   = 0;
  int items_sent    = 0;
  int sets_sent     = 0;
  int lengths_seen  = 0;
  int longest_seen  = 0;
  int in_idle_pct   = 0;
  int out_stall_pct = 0;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    int                 want;
  } set_row_t;

  // Directed sets, one row per beat. The run length is typed in where it is
  // obvious at a glance; other rows rely on the local model.
  localparam int DIRECTED_ROWS = 23;
  set_row_t directed_rows [DIRECTED_ROWS] = '{
    // Smallest value alone, straight after reset.
    '{10'd0,    1'b1, 1},
    // Largest value alone.
    '{10'd1023, 1'b1, 1},
    // The middle value joins an interval on each side.
    '{10'd5,    1'b0, PREDICTED},
    '{10'd7,    1'b0, PREDICTED},
    '{10'd6,    1'b1, 3},
    // Repeats are dropped, and a repeat still closes the set.
    '{10'd9,    1'b0, PREDICTED},
    '{10'd9,    1'b0, PREDICTED},
    '{10'd9,    1'b1, 1},
    // Runs that touch the top and the bottom of the domain.
    '{10'd1022, 1'b0, PREDICTED},
    '{10'd1023, 1'b1, 2},
    '{10'd1,    1'b0, PREDICTED},
    '{10'd0,    1'b1, 2},
    // Gaps filled in late, so merges chain across several intervals.
    '{10'd100,  1'b0, PREDICTED},
    '{10'd102,  1'b0, PREDICTED},
    '{10'd104,  1'b0, PREDICTED},
    '{10'd101,  1'b0, PREDICTED},
    '{10'd103,  1'b1, PREDICTED},
    // Values two apart never merge.
    '{10'd50,   1'b0, PREDICTED},
    '{10'd52,   1'b1, 1},
    // Growth below and above, then a repeat that closes the set.
    '{10'd512,  1'b0, PREDICTED},
    '{10'd511,  1'b0, PREDICTED},
    '{10'd513,  1'b0, PREDICTED},
    '{10'd511,  1'b1, PREDICTED}
  };

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("MISMATCH cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got,
               want);
    end
  endtask

  // Adds one value to the current set and merges it with its neighbors.
  function automatic void merge_value(input logic [VALUE_W-1:0] v);
    int lo;
    int hi;
    int span_len;
    lo = int'(v);
    hi = int'(v);
    if (lo >= DOMAIN || seen_in_set[lo]) begin
      return;
    end
    seen_in_set[lo] = 1'b1;
    // An interval starting just above reaches up to its recorded end.
    if (hi + 1 < DOMAIN && seen_in_set[hi + 1]) begin
      hi = int'(run_end_at[hi + 1]);
    end
    // An interval ending just below reaches down to its recorded start.
    if (lo > 0 && seen_in_set[lo - 1]) begin
      lo = int'(run_start_at[lo - 1]);
    end
    run_end_at[lo]   = VALUE_W'(hi);
    run_start_at[hi] = VALUE_W'(lo);
    span_len = (hi >= lo) ? hi - lo + 1 : 1;
    if (span_len > int'(best_run)) begin
      best_run = LEN_W'(span_len);
    end
  endfunction

  // Closes the set: returns its longest run and forgets its values.
  function automatic logic [LEN_W-1:0] close_set();
    logic [LEN_W-1:0] run_len;
    run_len = best_run;
    foreach (seen_in_set[i]) begin
      seen_in_set[i] = 1'b0;
    end
    best_run = '0;
    return run_len;
  endfunction

  // Offers one beat, with a random idle gap first, and waits until it is taken.
  // Valid stays high afterwards; the next call or the end lowers it.
  task automatic send_beat(input logic [VALUE_W-1:0] v, input logic l, input int want);
    logic [LEN_W-1:0] run_len;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      value_i    <= VALUE_W'($urandom);
      last_i     <= 1'($urandom);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    last_i     <= l;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    items_sent++;
    merge_value(v);
    if (l) begin
      run_len = close_set();
      pending_lengths.push_back((want == PREDICTED) ? run_len : LEN_W'(want));
      sets_sent++;
    end
  endtask

  // A short set, mostly values packed into a narrow window so that neighbors
  // merge and repeats occur; sometimes pressed against an end of the domain,
  // sometimes scattered over the whole domain.
  task automatic send_random_set();
    int count;
    int base;
    int shape;
    logic [VALUE_W-1:0] v;
    count = ($urandom_range(99) < 90) ? $urandom_range(1, 3) : $urandom_range(4, 8);
    shape = $urandom_range(99);
    base  = $urandom_range(DOMAIN - 1);
    if (shape < 5) begin
      base = 0;
    end else if (shape < 10) begin
      base = DOMAIN - count - 2;
    end
    for (int i = 0; i < count; i++) begin
      if (shape < 75) begin
        v = VALUE_W'(base + $urandom_range(0, count + 1));
      end else begin
        v = VALUE_W'($urandom);
      end
      send_beat(v, i == count - 1, PREDICTED);
    end
  endtask

  // Every value of the domain once, in random order: the longest possible run.
  task automatic send_full_domain();
    int order[DOMAIN];
    int j;
    int t;
    foreach (order[i]) begin
      order[i] = i;
    end
    for (int i = DOMAIN - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < DOMAIN; i++) begin
      send_beat(VALUE_W'(order[i]), i == DOMAIN - 1, PREDICTED);
    end
  endtask

  // Result monitor. The receiver stalls at random according to the phase.
  always @(posedge clk_i) begin : watch_results
    logic [LEN_W-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_lengths.size() == 0) begin
        report_mismatch("run length with no open set", int'(longest_length_o), 0);
      end else begin
        want = pending_lengths.pop_front();
        if (longest_length_o !== want) begin
          report_mismatch("longest_length", int'(longest_length_o), int'(want));
        end
        lengths_seen++;
        if (int'(longest_length_o) > longest_seen) begin
          longest_seen = int'(longest_length_o);
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d run lengths outstanding", cycle_count,
               pending_lengths.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int rand_sets;
    int waited;
    foreach (seen_in_set[i]) begin
      seen_in_set[i]  = 1'b0;
      run_end_at[i]   = '0;
      run_start_at[i] = '0;
    end
    best_run = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].value, directed_rows[i].last, directed_rows[i].want);
    end

    // Random sets in four phases of idling. The sweep of the presence memory
    // after the 255th set falls in the last phase.
    rand_sets = 0;
    while (items_sent < 1650 || rand_sets < 260) begin
      if (rand_sets < 70) begin
        in_idle_pct   = 0;
        out_stall_pct = 0;
      end else if (rand_sets < 140) begin
        in_idle_pct   = 58;
        out_stall_pct = 0;
      end else if (rand_sets < 210) begin
        in_idle_pct   = 0;
        out_stall_pct = 58;
      end else begin
        in_idle_pct   = 17;
        out_stall_pct = 17;
      end
      if (rand_sets == 100) begin
        send_full_domain();
      end else begin
        send_random_set();
      end
      rand_sets++;
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (pending_lengths.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    while (pending_lengths.size() != 0) begin
      report_mismatch("run length never delivered", -1, int'(pending_lengths.pop_front()));
    end

    $display("Sent %0d set elements in %0d sets, one covering the whole domain.",
             items_sent, sets_sent);
    $display("Checked %0d run lengths, the longest %0d, in %0d cycles.", lengths_seen,
             longest_seen, cycle_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/lcrm_pkg.sv
sv/lcrm_ram.sv
sv/lcrm_presence.sv
sv/lcrm_endpoints.sv
sv/longest_consecutive_run_merge.sv
tb/tb.sv
